// ===== src/gridrc_pkg.sv =====
`timescale 1ns / 1ps
package gridrc_pkg;

	localparam int MAX_COLUMNS = 64;
	localparam int MAX_ROWS    = 64;
	localparam int CELL_COUNT  = MAX_COLUMNS * MAX_ROWS;

	localparam int ADDR_W  = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
	localparam int POS_W   = $clog2(CELL_COUNT + 1);
	localparam int COLS_W  = $clog2(MAX_COLUMNS + 1);
	localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
	localparam int X_W     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int CFG_W   = 7;
	localparam int TILE_W  = 16;
	localparam int COORD_W = 6;

	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_GRID_COLUMNS = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS    = 1'd1;
	localparam logic [CFG_W-1:0] GRID_COLUMNS_RESET = 7'd64;
	localparam logic [CFG_W-1:0] GRID_ROWS_RESET    = 7'd64;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_FIND = 1'b1;

	// One memory entry per cell: solid bit above the visited bit.
	localparam int MEM_W       = 2;
	localparam int MEM_SOLID   = 1;
	localparam int MEM_VISITED = 0;

	typedef struct packed {
		logic              wr;
		logic [COLS_W-1:0] cols;
		logic [ROWS_W-1:0] rows;
		logic [POS_W-1:0]  total;
	} grid_cfg_t;

	typedef struct packed {
		logic               found;
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] bottom;
	} rect_t;

endpackage

// ===== src/gridrc_ram.sv =====
`timescale 1ns / 1ps
module gridrc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/gridrc_ctrl.sv =====
`timescale 1ns / 1ps
module gridrc_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  gridrc_pkg::grid_cfg_t             cfg,
	input  logic                              start,
	input  logic                              func,
	input  logic signed [gridrc_pkg::TILE_W-1:0] tile_index,
	output logic                              ready,
	output logic                              res_valid,
	output gridrc_pkg::rect_t                 res,
	input  logic                              res_take
);

	import gridrc_pkg::*;

	localparam logic [3:0] ST_CLEAR   = 4'd0;
	localparam logic [3:0] ST_IDLE    = 4'd1;
	localparam logic [3:0] ST_LOAD    = 4'd2;
	localparam logic [3:0] ST_FIND    = 4'd3;
	localparam logic [3:0] ST_DIV     = 4'd4;
	localparam logic [3:0] ST_SCAN_RD = 4'd5;
	localparam logic [3:0] ST_SCAN_EV = 4'd6;
	localparam logic [3:0] ST_GROW_RD = 4'd7;
	localparam logic [3:0] ST_GROW_EV = 4'd8;
	localparam logic [3:0] ST_MARK_IN = 4'd9;
	localparam logic [3:0] ST_MARK    = 4'd10;
	localparam logic [3:0] ST_DONE    = 4'd11;

	// Control state.
	logic [3:0]        state_q, state_d;
	logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
	logic [ADDR_W-1:0] load_pos_q, load_pos_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [X_W-1:0]    px_q, px_d;
	logic [ROWS_W-1:0] py_q, py_d;
	logic              stale_q, stale_d;

	// Work registers of one item.
	logic              solid_q, solid_d;
	logic [POS_W-1:0]  rem_q, rem_d;
	logic [X_W-1:0]    x0_q, x0_d;
	logic [ROWS_W-1:0] y0_q, y0_d;
	logic [ADDR_W-1:0] start_addr_q, start_addr_d;
	logic [X_W-1:0]    cx_q, cx_d;
	logic [ROWS_W-1:0] yy_q, yy_d;
	logic [X_W-1:0]    right_q, right_d;
	logic [ROWS_W-1:0] bottom_q, bottom_d;
	logic [ADDR_W-1:0] row_addr_q, row_addr_d;
	logic [ADDR_W-1:0] cell_addr_q, cell_addr_d;
	logic              found_q, found_d;

	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [MEM_W-1:0]  mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [MEM_W-1:0]  mem_rdata;

	logic              cell_open;
	logic [X_W-1:0]    last_col;
	logic [ADDR_W-1:0] cols_addr;
	logic [ADDR_W-1:0] next_row_addr;
	logic [ADDR_W-1:0] load_p;
	logic [POS_W-1:0]  load_next;

	gridrc_ram #(
		.WIDTH (MEM_W),
		.DEPTH (CELL_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign cell_open     = mem_rdata[MEM_SOLID] & ~mem_rdata[MEM_VISITED];
	assign last_col      = X_W'(cfg.cols - 1'b1);
	assign cols_addr     = ADDR_W'(cfg.cols);
	assign next_row_addr = row_addr_q + cols_addr;
	assign load_p        = (POS_W'(load_pos_q) >= cfg.total) ? '0 : load_pos_q;
	assign load_next     = POS_W'(load_p) + 1'b1;

	assign ready     = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		res.found  = found_q;
		res.left   = found_q ? COORD_W'(x0_q) : '0;
		res.top    = found_q ? COORD_W'(y0_q) : '0;
		res.right  = found_q ? COORD_W'(right_q) : '0;
		res.bottom = found_q ? COORD_W'(bottom_q) : '0;
	end

	always_comb begin
		state_d      = state_q;
		clr_addr_d   = clr_addr_q;
		load_pos_d   = load_pos_q;
		pos_d        = pos_q;
		px_d         = px_q;
		py_d         = py_q;
		stale_d      = stale_q | cfg.wr;
		solid_d      = solid_q;
		rem_d        = rem_q;
		x0_d         = x0_q;
		y0_d         = y0_q;
		start_addr_d = start_addr_q;
		cx_d         = cx_q;
		yy_d         = yy_q;
		right_d      = right_q;
		bottom_d     = bottom_q;
		row_addr_d   = row_addr_q;
		cell_addr_d  = cell_addr_q;
		found_d      = found_q;
		mem_we       = 1'b0;
		mem_waddr    = cell_addr_q;
		mem_wdata    = '0;
		mem_raddr    = cell_addr_q;

		case (state_q)
			ST_CLEAR: begin
				mem_we     = 1'b1;
				mem_waddr  = clr_addr_q;
				clr_addr_d = clr_addr_q + 1'b1;
				if (clr_addr_q == ADDR_W'(CELL_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					solid_d = ~tile_index[TILE_W-1] & (tile_index != '0);
					state_d = (func == FUNC_LOAD) ? ST_LOAD : ST_FIND;
				end
			end
			ST_LOAD: begin
				mem_we    = 1'b1;
				mem_waddr = load_p;
				mem_wdata[MEM_SOLID]   = solid_q;
				mem_wdata[MEM_VISITED] = 1'b0;
				load_pos_d = (load_next >= cfg.total) ? '0 : ADDR_W'(load_next);
				pos_d   = '0;
				px_d    = '0;
				py_d    = '0;
				stale_d = 1'b0;
				state_d = ST_IDLE;
			end
			ST_FIND: begin
				found_d = 1'b0;
				if (pos_q >= cfg.total) begin
					state_d = ST_DONE;
				end else if (stale_q) begin
					rem_d   = pos_q;
					py_d    = '0;
					state_d = ST_DIV;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_DIV: begin
				// Column and row of the scan position under the current width.
				if (rem_q >= POS_W'(cfg.cols)) begin
					rem_d = rem_q - POS_W'(cfg.cols);
					py_d  = py_q + 1'b1;
				end else begin
					px_d    = X_W'(rem_q);
					stale_d = 1'b0;
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				mem_raddr = ADDR_W'(pos_q);
				if (pos_q >= cfg.total) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_SCAN_EV;
				end
			end
			ST_SCAN_EV: begin
				pos_d = pos_q + 1'b1;
				if (px_q == last_col) begin
					px_d = '0;
					py_d = py_q + 1'b1;
				end else begin
					px_d = px_q + 1'b1;
				end
				if (cell_open) begin
					x0_d         = px_q;
					y0_d         = py_q;
					start_addr_d = ADDR_W'(pos_q);
					cx_d         = px_q;
					yy_d         = py_q;
					right_d      = last_col;
					row_addr_d   = ADDR_W'(pos_q);
					cell_addr_d  = ADDR_W'(pos_q);
					state_d      = ST_GROW_RD;
				end else begin
					// A cell the scan steps over is marked visited until a load writes it again.
					mem_we    = 1'b1;
					mem_waddr = ADDR_W'(pos_q);
					mem_wdata[MEM_SOLID]   = mem_rdata[MEM_SOLID];
					mem_wdata[MEM_VISITED] = 1'b1;
					state_d = ST_SCAN_RD;
				end
			end
			ST_GROW_RD: begin
				mem_raddr = cell_addr_q;
				if (yy_q == cfg.rows) begin
					bottom_d = ROWS_W'(cfg.rows - 1'b1);
					state_d  = ST_MARK_IN;
				end else begin
					state_d = ST_GROW_EV;
				end
			end
			ST_GROW_EV: begin
				if (!cell_open && cx_q == x0_q) begin
					bottom_d = ROWS_W'(yy_q - 1'b1);
					state_d  = ST_MARK_IN;
				end else if (!cell_open || cx_q == right_q) begin
					if (!cell_open) begin
						right_d = X_W'(cx_q - 1'b1);
					end
					yy_d        = yy_q + 1'b1;
					row_addr_d  = next_row_addr;
					cell_addr_d = next_row_addr;
					cx_d        = x0_q;
					state_d     = ST_GROW_RD;
				end else begin
					cx_d        = cx_q + 1'b1;
					cell_addr_d = cell_addr_q + 1'b1;
					state_d     = ST_GROW_RD;
				end
			end
			ST_MARK_IN: begin
				yy_d        = y0_q;
				cx_d        = x0_q;
				row_addr_d  = start_addr_q;
				cell_addr_d = start_addr_q;
				state_d     = ST_MARK;
			end
			ST_MARK: begin
				// Every cell inside the rectangle was found solid while growing.
				mem_we    = 1'b1;
				mem_waddr = cell_addr_q;
				mem_wdata[MEM_SOLID]   = 1'b1;
				mem_wdata[MEM_VISITED] = 1'b1;
				if (cx_q == right_q) begin
					if (yy_q == bottom_q) begin
						found_d = 1'b1;
						state_d = ST_DONE;
					end else begin
						yy_d        = yy_q + 1'b1;
						row_addr_d  = next_row_addr;
						cell_addr_d = next_row_addr;
						cx_d        = x0_q;
					end
				end else begin
					cx_d        = cx_q + 1'b1;
					cell_addr_d = cell_addr_q + 1'b1;
				end
			end
			ST_DONE: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			load_pos_q <= '0;
			pos_q      <= '0;
			px_q       <= '0;
			py_q       <= '0;
			stale_q    <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_addr_q <= clr_addr_d;
			load_pos_q <= load_pos_d;
			pos_q      <= pos_d;
			px_q       <= px_d;
			py_q       <= py_d;
			stale_q    <= stale_d;
			found_q    <= found_d;
		end
	end

	always_ff @(posedge clk) begin
		solid_q      <= solid_d;
		rem_q        <= rem_d;
		x0_q         <= x0_d;
		y0_q         <= y0_d;
		start_addr_q <= start_addr_d;
		cx_q         <= cx_d;
		yy_q         <= yy_d;
		right_q      <= right_d;
		bottom_q     <= bottom_d;
		row_addr_q   <= row_addr_d;
		cell_addr_q  <= cell_addr_d;
	end

endmodule

// ===== src/grid_rectangle_cover.sv =====
`timescale 1ns / 1ps
// Load word: the cell is written in the cycle after acceptance, and the next word is taken once
// LOAD has returned to IDLE; no result word.
// Find word: each cell the scan steps over is read and evaluated (SCAN_RD, SCAN_EV), as is each
// cell tested while growing (GROW_RD, GROW_EV); MARK writes each marked cell, and a register
// write makes DIV redo the scan position first. Cell memory: one read and one write a cycle,
// read data registered. One word is in work at a time; a result waits in the output register.
// After reset a clearing pass over all 4096 cells (one cell a cycle) runs before the first word.
module grid_rectangle_cover (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [15:0]                          s_axis_tdata,  // [15:0] tile_index
	input  logic [0:0]                           s_axis_tuser,  // [0] func
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [5:0] rect_left, [11:6] rect_top, [17:12] rect_right, [23:18] rect_bottom
	output logic [23:0]                          m_axis_tdata,
	output logic [0:0]                           m_axis_tuser,  // [0] rect_found
	input  logic                                 cfg_we,
	input  logic [gridrc_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [gridrc_pkg::CFG_W-1:0]         cfg_wdata
);

	import gridrc_pkg::*;

	logic [CFG_W-1:0]  grid_columns_q;
	logic [CFG_W-1:0]  grid_rows_q;
	logic [POS_W-1:0]  total_q;
	logic [COLS_W-1:0] cols_sat;
	logic [ROWS_W-1:0] rows_sat;
	grid_cfg_t         cfg;

	logic              ctrl_ready;
	logic              res_valid;
	rect_t             res;
	logic              out_free;

	logic              m_valid_q;
	logic [23:0]       m_data_q;
	logic              m_found_q;

	always_comb begin
		if (grid_columns_q == '0) begin
			cols_sat = COLS_W'(1);
		end else if (int'(grid_columns_q) > MAX_COLUMNS) begin
			cols_sat = COLS_W'(MAX_COLUMNS);
		end else begin
			cols_sat = COLS_W'(grid_columns_q);
		end
		if (grid_rows_q == '0) begin
			rows_sat = ROWS_W'(1);
		end else if (int'(grid_rows_q) > MAX_ROWS) begin
			rows_sat = ROWS_W'(MAX_ROWS);
		end else begin
			rows_sat = ROWS_W'(grid_rows_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_columns_q <= GRID_COLUMNS_RESET;
			grid_rows_q    <= GRID_ROWS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_COLUMNS: grid_columns_q <= cfg_wdata;
				REG_GRID_ROWS:    grid_rows_q    <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		total_q <= POS_W'(cols_sat) * POS_W'(rows_sat);
	end

	assign cfg.wr    = cfg_we;
	assign cfg.cols  = cols_sat;
	assign cfg.rows  = rows_sat;
	assign cfg.total = total_q;

	assign out_free = ~m_valid_q | m_axis_tready;

	gridrc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.start      (s_axis_tvalid & ctrl_ready),
		.func       (s_axis_tuser[0]),
		.tile_index (s_axis_tdata),
		.ready      (ctrl_ready),
		.res_valid  (res_valid),
		.res        (res),
		.res_take   (out_free)
	);

	assign s_axis_tready = ctrl_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			m_found_q <= res.found;
			m_data_q  <= {res.bottom, res.right, res.top, res.left};
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = m_data_q;
	assign m_axis_tuser[0] = m_found_q;

endmodule
